// File: rtl/core/sharpen_3x3_stencil_core_assert.svh
// assertion macros for the sharpen stencil core
`ifndef SHARPEN_3X3_STENCIL_CORE_ASSERT_SVH
`define SHARPEN_3X3_STENCIL_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SHRP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sharpen core assertion failed");
`define SHRP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("sharpen core forbidden condition seen");
`else
`define SHRP_ASSERT(lbl, prop)
`define SHRP_ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: rtl/core/shrp_pkg.sv
// shared types and constants of the sharpen stencil core
`timescale 1ns / 1ps
package shrp_pkg;

  localparam int PIX_W          = 24;
  localparam int CH_W           = 8;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int CFG_W_BITS     = 12;
  localparam int CFG_H_BITS     = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;
  localparam int MAX_RESULTS    = 4;
  // power of two, pointers wrap
  localparam int RES_DEPTH      = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_KERNEL_MODE  = 2'd2
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;

  // [0] two rows up, [1] one row up, [2] current row
  typedef pix_t [2:0] col_t;

  typedef struct packed {
    pix_t nw;
    pix_t n;
    pix_t ne;
    pix_t w;
    pix_t c;
    pix_t e;
    pix_t sw;
    pix_t s;
    pix_t se;
  } taps_t;

  typedef struct packed {
    logic eoi;
    logic last;
    pix_t pixel;
  } res_t;

endpackage

// File: rtl/core/shrp_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module shrp_ram #(
  parameter int WIDTH = shrp_pkg::PIX_W,
  parameter int DEPTH = shrp_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/shrp_kernel.sv
// 3x3 sharpen kernel, 5-point or 9-point by mode_i, over three colour channels with clamping
`timescale 1ns / 1ps
module shrp_kernel (
  input  shrp_pkg::taps_t taps_i,
  input  logic            mode_i,
  output shrp_pkg::pix_t  pixel_o
);

  import shrp_pkg::*;

  localparam int S4W = CH_W + 2;
  localparam int S8W = CH_W + 3;
  localparam int C9W = CH_W + 4;
  localparam int VW  = CH_W + 5;

  for (genvar g = 0; g < 3; g++) begin : g_ch
    logic [CH_W-1:0]      nw, n, ne, w, c, e, sw, s, se;
    logic [S4W-1:0]       sum4;
    logic [S8W-1:0]       sum8;
    logic [S8W-1:0]       c5;
    logic [C9W-1:0]       c9;
    logic signed [VW-1:0] v;

    assign nw = taps_i.nw[g*CH_W +: CH_W];
    assign n  = taps_i.n[g*CH_W +: CH_W];
    assign ne = taps_i.ne[g*CH_W +: CH_W];
    assign w  = taps_i.w[g*CH_W +: CH_W];
    assign c  = taps_i.c[g*CH_W +: CH_W];
    assign e  = taps_i.e[g*CH_W +: CH_W];
    assign sw = taps_i.sw[g*CH_W +: CH_W];
    assign s  = taps_i.s[g*CH_W +: CH_W];
    assign se = taps_i.se[g*CH_W +: CH_W];

    assign sum4 = S4W'(n) + S4W'(s) + S4W'(w) + S4W'(e);
    assign sum8 = S8W'(sum4) + S8W'(nw) + S8W'(ne) + S8W'(sw) + S8W'(se);
    assign c5   = (S8W'(c) << 2) + S8W'(c);
    assign c9   = (C9W'(c) << 3) + C9W'(c);

    assign v = mode_i ? ($signed(VW'(c9)) - $signed(VW'(sum8)))
                      : ($signed(VW'(c5)) - $signed(VW'(sum4)));

    // clamp to the channel range
    assign pixel_o[g*CH_W +: CH_W] = v[VW-1]               ? '0 :
                                     (|v[VW-2:CH_W])       ? {CH_W{1'b1}} :
                                     v[CH_W-1:0];
  end

endmodule

// File: rtl/core/shrp_res_fifo.sv
// result queue taking up to four results per cycle and giving one per cycle while ready_i is high
`timescale 1ns / 1ps
module shrp_res_fifo (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [shrp_pkg::MAX_RESULTS-1:0]         push_i,
  input  shrp_pkg::res_t [shrp_pkg::MAX_RESULTS-1:0] push_data_i,
  output logic [$clog2(shrp_pkg::RES_DEPTH+1)-1:0] count_o,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output shrp_pkg::res_t                           data_o
);

  import shrp_pkg::*;

  localparam int PW = $clog2(RES_DEPTH);
  localparam int CW = $clog2(RES_DEPTH + 1);

  res_t          mem_q [RES_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] slot [MAX_RESULTS];
  logic [CW-1:0] n_push;
  logic          pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o & ready_i;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  // packed slots for the results that are present
  always_comb begin
    n_push = '0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      slot[k] = wr_ptr_q + PW'(n_push);
      n_push  = n_push + CW'(push_i[k]);
    end
    wr_ptr_d = wr_ptr_q + PW'(n_push);
    rd_ptr_d = rd_ptr_q + PW'(pop);
    count_d  = count_q + n_push - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (push_i[k]) begin
        mem_q[slot[k]] <= push_data_i[k];
      end
    end
  end

endmodule

// File: rtl/core/sharpen_3x3_stencil_core.sv
// top level of the 3x3 sharpen stencil core
//
//  channel   dir  handshake                        carries
//  s_axis    in   s_axis_tvalid / s_axis_tready    in_pixel
//  m_axis    out  m_axis_tvalid / m_axis_tready    out_pixel, last_of_run, end_of_image
//  cfg       in   cfg_valid_i / cfg_ready_o        register index and value
//
//  one pixel item per cycle unless stalled; line store read on accept, kernels next cycle
//  results (0-4 per item) enter a 16-entry queue, leave one per cycle if m_axis_tready
//  s_axis_tready drops while the queue lacks room for two items' worth of results
//  results reach m_axis through the input register stage and the result queue
//  reset clears counters, queue, configuration and stage valid; line stores need no clearing pass
`timescale 1ns / 1ps
`include "sharpen_3x3_stencil_core_assert.svh"
module sharpen_3x3_stencil_core #(
  parameter int MAX_WIDTH  = shrp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = shrp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [shrp_pkg::PIX_W-1:0]       s_axis_tdata,  // in_pixel
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [shrp_pkg::PIX_W-1:0]       m_axis_tdata,  // out_pixel
  output logic                             m_axis_tlast,  // last_of_run
  output logic                             m_axis_tuser,  // end_of_image
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [shrp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [shrp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import shrp_pkg::*;

  localparam int CLW      = $clog2(MAX_WIDTH);
  localparam int RWB      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCW      = (CFG_W_BITS > CLW + 1) ? CFG_W_BITS : CLW + 1;
  localparam int HCW      = (CFG_H_BITS > RWB + 1) ? CFG_H_BITS : RWB + 1;
  localparam int CW       = $clog2(RES_DEPTH + 1);
  localparam int RES_ROOM = RES_DEPTH - 2 * MAX_RESULTS;

  // configuration
  logic [CFG_W_BITS-1:0] width_q;
  logic [CFG_H_BITS-1:0] height_q;
  logic                  mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W_BITS'(WIDTH_RESET);
      height_q <= CFG_H_BITS'(HEIGHT_RESET);
      mode_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[CFG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[CFG_H_BITS-1:0];
        REG_KERNEL_MODE:  mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // position counters
  logic [CLW-1:0] col_q;
  logic [RWB-1:0] row_q;
  logic [WCW-1:0] w_eff;
  logic [HCW-1:0] h_eff;
  logic           last_col, last_row;
  logic           accept;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WCW'(1);
    end else if (WCW'(width_q) > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HCW'(1);
    end else if (HCW'(height_q) > HCW'(MAX_HEIGHT)) begin
      h_eff = HCW'(MAX_HEIGHT);
    end else begin
      h_eff = HCW'(height_q);
    end
  end

  assign last_col = (WCW'(col_q) + WCW'(1)) >= w_eff;
  assign last_row = (HCW'(row_q) + HCW'(1)) >= h_eff;
  assign accept   = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RWB'(1);
      end else begin
        col_q <= col_q + CLW'(1);
      end
    end
  end

  // input register stage
  logic           b_valid_q;
  pix_t           b_pix_q;
  logic [CLW-1:0] b_col_q;
  logic           b_row0_q, b_row1_q, b_lc_q, b_lr_q, b_col0_q;
  logic           b_fwd_q;
  pix_t           b_fwd_recent_q, b_fwd_older_q;
  pix_t           recent_rdata, older_rdata;
  pix_t           recent_eff, older_eff;

  // same column written by the item ahead: take its values
  assign recent_eff = b_fwd_q ? b_fwd_recent_q : recent_rdata;
  assign older_eff  = b_fwd_q ? b_fwd_older_q : older_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_pix_q        <= s_axis_tdata;
      b_col_q        <= col_q;
      b_row0_q       <= (row_q == '0);
      b_row1_q       <= (row_q == RWB'(1));
      b_lc_q         <= last_col;
      b_lr_q         <= last_row;
      b_col0_q       <= (col_q == '0);
      b_fwd_q        <= b_valid_q && (b_col_q == col_q);
      b_fwd_recent_q <= b_pix_q;
      b_fwd_older_q  <= recent_eff;
    end
  end

  shrp_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_col_q),
    .wdata_i (recent_eff),
    .raddr_i (col_q),
    .rdata_o (older_rdata)
  );

  shrp_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_recent_ram (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_col_q),
    .wdata_i (b_pix_q),
    .raddr_i (col_q),
    .rdata_o (recent_rdata)
  );

  // window
  col_t t_col, lf_q, md_q, lf_new, md_new;

  always_comb begin
    t_col[2] = b_pix_q;
    t_col[1] = b_row0_q ? b_pix_q : recent_eff;
    t_col[0] = b_row0_q ? b_pix_q : (b_row1_q ? recent_eff : older_eff);
  end

  assign lf_new = b_col0_q ? t_col : md_q;
  assign md_new = t_col;

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      lf_q <= lf_new;
      md_q <= md_new;
    end
  end

  function automatic taps_t make_taps(col_t lf, col_t md, col_t rt, logic lower);
    taps_t tp;
    if (!lower) begin
      tp.nw = lf[0]; tp.n = md[0]; tp.ne = rt[0];
      tp.w  = lf[1]; tp.c = md[1]; tp.e  = rt[1];
      tp.sw = lf[2]; tp.s = md[2]; tp.se = rt[2];
    end else begin
      tp.nw = lf[1]; tp.n = md[1]; tp.ne = rt[1];
      tp.w  = lf[2]; tp.c = md[2]; tp.e  = rt[2];
      tp.sw = lf[2]; tp.s = md[2]; tp.se = rt[2];
    end
    return tp;
  endfunction

  taps_t                   taps [MAX_RESULTS];
  pix_t                    res_pix [MAX_RESULTS];
  logic [MAX_RESULTS-1:0]  push_v;
  res_t [MAX_RESULTS-1:0]  push_data;

  // completed column, then the right edge column on the row's last item
  assign taps[0] = make_taps(lf_q, md_q, t_col, 1'b0);
  assign taps[1] = make_taps(lf_q, md_q, t_col, 1'b1);
  assign taps[2] = make_taps(lf_new, md_new, md_new, 1'b0);
  assign taps[3] = make_taps(lf_new, md_new, md_new, 1'b1);

  for (genvar k = 0; k < MAX_RESULTS; k++) begin : g_kernel
    shrp_kernel u_kernel (
      .taps_i  (taps[k]),
      .mode_i  (mode_q),
      .pixel_o (res_pix[k])
    );
  end

  assign push_v[0] = b_valid_q & ~b_col0_q & ~b_row0_q;
  assign push_v[1] = b_valid_q & ~b_col0_q & b_lr_q;
  assign push_v[2] = b_valid_q & b_lc_q & ~b_row0_q;
  assign push_v[3] = b_valid_q & b_lc_q & b_lr_q;

  always_comb begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      push_data[k].pixel = res_pix[k];
      push_data[k].last  = push_v[k] & ~(|(push_v >> (k + 1)));
      push_data[k].eoi   = push_data[k].last & b_lc_q & b_lr_q;
    end
  end

  // result queue
  logic [CW-1:0] count;
  logic [CW:0]   room_need;
  res_t          out_res;

  shrp_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_v),
    .push_data_i (push_data),
    .count_o     (count),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_res)
  );

  assign room_need     = (CW+1)'(count) + (b_valid_q ? (CW+1)'(MAX_RESULTS) : '0);
  assign s_axis_tready = room_need <= (CW+1)'(RES_ROOM);

  assign m_axis_tdata = out_res.pixel;
  assign m_axis_tlast = out_res.last;
  assign m_axis_tuser = out_res.eoi;

  `SHRP_ASSERT(a_accept_loads_stage, accept |=> b_valid_q)
  `SHRP_ASSERT_NEVER(a_queue_overflow, count > CW'(RES_DEPTH))
  `SHRP_ASSERT(a_eoi_is_last, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
  `SHRP_ASSERT(a_eoi_wraps_counters, (b_valid_q && b_lc_q && b_lr_q) |-> (col_q == '0 && row_q == '0))

endmodule
